FILE: rtl/core/b64u_pkg.sv
// b64u_pkg: shared types, character constants and the sextet-to-ascii map
// for the base64url stream encoder; no dependencies
`default_nettype none

package b64u_pkg;

  // position of the next byte within its 3-byte group
  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } pos_t;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_USCORE  = 8'h5F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_DASH  = 6'd62;

  // characters produced by one byte, taken out one per cycle by the back end unless the output stalls
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            last_end;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < SEXTET_LOWER) begin
      c = CHAR_UPPER_A + {2'b00, v};
    end else if (v < SEXTET_DIGIT) begin
      c = CHAR_LOWER_A + {2'b00, v - SEXTET_LOWER};
    end else if (v < SEXTET_DASH) begin
      c = CHAR_ZERO + {2'b00, v - SEXTET_DIGIT};
    end else if (v == SEXTET_DASH) begin
      c = CHAR_DASH;
    end else begin
      c = CHAR_USCORE;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/base64url_stream_encoder.sv
// base64url_stream_encoder: top level, byte in, url-safe base64 characters out
// depends on b64u_pkg, b64u_front, b64u_queue, b64u_back
// the first character of an item passes the queue register, then the back end output register
// throughput: one character per cycle from the back end output register while out_ready is high;
//   an item gives 1 to 4 characters, about 4/3 characters per byte sustained
// reset: rst_n synchronous active low, clears group state, queue and output
`default_nettype none

module base64url_stream_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_final_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_code_char,
  output logic            out_end_of_text
);

  // front to queue
  logic           push;
  b64u_pkg::job_t push_job;
  logic           q_full;

  // queue to back
  logic           q_not_empty;
  logic           q_pop;
  b64u_pkg::job_t head_job;

  // a byte is taken whenever the queue has room, independent of the output side
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // front: group position and carry bits, builds all characters of one byte
  b64u_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .job        (push_job)
  );

  // queue decouples byte intake from character output
  b64u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // back: one character per cycle into the output register unless out_ready stalls it
  b64u_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (q_not_empty),
    .job             (head_job),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_char   (out_code_char),
    .out_end_of_text (out_end_of_text)
  );

endmodule

`default_nettype wire

FILE: rtl/core/b64u_front.sv
// b64u_front: takes bytes, tracks group position and carry bits, and builds
// the job of characters each byte causes; depends on b64u_pkg
`default_nettype none

module b64u_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [7:0]    data_byte,
  input  wire logic          final_byte,
  output b64u_pkg::job_t     job
);

  b64u_pkg::pos_t pos_r, pos_nxt;
  logic [3:0]     carry_r, carry_nxt;

  always_comb begin
    job       = '0;
    pos_nxt   = pos_r;
    carry_nxt = carry_r;
    case (pos_r)
      b64u_pkg::POS_SECOND: begin
        job.chars[0] = b64u_pkg::sextet_char({carry_r[1:0], data_byte[7:4]});
        if (final_byte) begin
          job.chars[1] = b64u_pkg::sextet_char({data_byte[3:0], 2'b00});
          job.chars[2] = b64u_pkg::CHAR_PAD;
          job.last_idx = 2'd2;
          job.last_end = 1'b1;
          pos_nxt      = b64u_pkg::POS_FIRST;
          carry_nxt    = 4'd0;
        end else begin
          pos_nxt   = b64u_pkg::POS_THIRD;
          carry_nxt = data_byte[3:0];
        end
      end
      b64u_pkg::POS_THIRD: begin
        job.chars[0] = b64u_pkg::sextet_char({carry_r, data_byte[7:6]});
        job.chars[1] = b64u_pkg::sextet_char(data_byte[5:0]);
        job.last_idx = 2'd1;
        job.last_end = final_byte;
        pos_nxt      = b64u_pkg::POS_FIRST;
        carry_nxt    = 4'd0;
      end
      default: begin
        job.chars[0] = b64u_pkg::sextet_char(data_byte[7:2]);
        if (final_byte) begin
          job.chars[1] = b64u_pkg::sextet_char({data_byte[1:0], 4'b0000});
          job.chars[2] = b64u_pkg::CHAR_PAD;
          job.chars[3] = b64u_pkg::CHAR_PAD;
          job.last_idx = 2'd3;
          job.last_end = 1'b1;
          pos_nxt      = b64u_pkg::POS_FIRST;
          carry_nxt    = 4'd0;
        end else begin
          pos_nxt   = b64u_pkg::POS_SECOND;
          carry_nxt = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= b64u_pkg::POS_FIRST;
      carry_r <= 4'd0;
    end else if (push) begin
      pos_r   <= pos_nxt;
      carry_r <= carry_nxt;
    end
  end

  // a final byte always closes the group
  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    push && final_byte |=> pos_r == b64u_pkg::POS_FIRST && carry_r == 4'd0)
    else $error("final byte did not restart the group");

  // the job of a final byte always carries the end mark, at every position
  a_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
    push && final_byte |-> job.last_end)
    else $error("final byte job lacks end mark");

endmodule

`default_nettype wire

FILE: rtl/core/b64u_queue.sv
// b64u_queue: short fifo of jobs between front and back end;
// depends on b64u_pkg
`default_nettype none

module b64u_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  b64u_pkg::job_t     push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output b64u_pkg::job_t     head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  b64u_pkg::job_t store_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full      = (count_r == DEPTH_CNT);
  assign not_empty = (count_r != '0);
  assign head_job  = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/core/b64u_back.sv
// b64u_back: walks the head job one character per cycle into the output
// register unless out_ready stalls it; depends on b64u_pkg
`default_nettype none

module b64u_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  input  b64u_pkg::job_t     job,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_code_char,
  output logic               out_end_of_text
);

  logic       valid_r;
  logic [7:0] code_r;
  logic       end_r;
  logic [1:0] idx_r;
  logic       load;
  logic       at_last;

  assign load    = job_valid && (!valid_r || out_ready);
  assign at_last = (idx_r == job.last_idx);
  assign pop     = load && at_last;

  assign out_valid       = valid_r;
  assign out_code_char   = code_r;
  assign out_end_of_text = end_r;

  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= job.chars[idx_r];
      end_r  <= at_last && job.last_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // character index never runs past the head job
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> idx_r <= job.last_idx)
    else $error("character index beyond job");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: byte items into base64url_stream_encoder, every character item checked
// against an in-bench url-safe base64 encoder; depends on b64u_pkg and the rtl

module testbench;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 200;
  localparam int HOLD_CYCLES   = 120;

  // url-safe alphabet, index 0 is the leftmost character
  localparam logic [0:63][7:0] URL_ALPHABET = {
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    "abcdefghijklmnopqrstuvwxyz",
    "0123456789-_"
  };

  typedef struct packed {
    logic [7:0] code_char;
    logic       end_of_text;
  } enc_char_t;

  // every block input known from time zero
  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic [7:0] in_data_byte  = 8'h00;
  logic       in_final_byte = 1'b0;
  logic       out_ready     = 1'b0;

  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_code_char;
  logic       out_end_of_text;

  // characters still owed by the block, oldest first
  enc_char_t  expected_chars[$];

  // encoder state of the in-bench model
  b64u_pkg::pos_t group_pos    = b64u_pkg::POS_FIRST;
  logic [3:0]     carry_nibble = 4'h0;

  int         mismatch_count = 0;
  int         cycle_count    = 0;
  int         idle_pct       = 0;   // chance per item or cycle of a gap, in percent
  int         hold_request   = 0;   // cycles of receiver hold-off asked by a test
  int         stall_left     = 0;
  logic [7:0] msg_bytes[$];

  base64url_stream_encoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_char   (out_code_char),
    .out_end_of_text (out_end_of_text)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit, far above the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll >= idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // message length: mostly short, a few long ones
  function automatic int pick_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 9);
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic last);
    enc_char_t c;
    c.code_char   = ch;
    c.end_of_text = last;
    expected_chars.push_back(c);
  endtask

  // model of the encoder: one accepted byte in, its characters queued
  task automatic predict_encode(input logic [7:0] b, input logic fin);
    case (group_pos)
      b64u_pkg::POS_SECOND: begin
        // two carried bits and the high nibble
        push_char(URL_ALPHABET[{carry_nibble[1:0], b[7:4]}], 1'b0);
        if (fin) begin
          // two bytes left over: zero fill, one pad
          push_char(URL_ALPHABET[{b[3:0], 2'b00}], 1'b0);
          push_char(b64u_pkg::CHAR_PAD, 1'b1);
          group_pos    = b64u_pkg::POS_FIRST;
          carry_nibble = 4'h0;
        end else begin
          group_pos    = b64u_pkg::POS_THIRD;
          carry_nibble = b[3:0];
        end
      end
      b64u_pkg::POS_THIRD: begin
        // group completes, no padding even when final
        push_char(URL_ALPHABET[{carry_nibble, b[7:6]}], 1'b0);
        push_char(URL_ALPHABET[b[5:0]], fin);
        group_pos    = b64u_pkg::POS_FIRST;
        carry_nibble = 4'h0;
      end
      default: begin
        // first byte of a group, an unused position acts the same
        push_char(URL_ALPHABET[b[7:2]], 1'b0);
        if (fin) begin
          // one byte left over: zero fill, two pads
          push_char(URL_ALPHABET[{b[1:0], 4'h0}], 1'b0);
          push_char(b64u_pkg::CHAR_PAD, 1'b0);
          push_char(b64u_pkg::CHAR_PAD, 1'b1);
          group_pos    = b64u_pkg::POS_FIRST;
          carry_nibble = 4'h0;
        end else begin
          group_pos    = b64u_pkg::POS_SECOND;
          carry_nibble = {2'b00, b[1:0]};
        end
      end
    endcase
  endtask

  // offer one byte after a gap, hold it until accepted, then predict;
  // valid stays high on return so back-to-back items see no bubble
  task automatic send_byte(input logic [7:0] b, input logic fin, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_encode(b, fin);
  endtask

  // send msg_bytes as one message, final flag on the last byte
  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1, pick_gap());
    end
  endtask

  task automatic fill_random_message(input int len);
    msg_bytes.delete();
    repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // the byte already taken must not be offered again while waiting
  task automatic wait_drained();
    if (expected_chars.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clk);
    end
  endtask

  // receiver: random stalls, plus a long hold-off when a test asks for one
  always @(posedge clk) begin
    if (hold_request > 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // compare each accepted character item with the oldest expectation
  always @(posedge clk) begin : char_check
    enc_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected item, char %h end %b", $time, out_code_char,
                 out_end_of_text);
        mismatch_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_code_char !== want.code_char) begin
          $display("%0t: code_char expected %h actual %h", $time, want.code_char,
                   out_code_char);
          mismatch_count++;
        end
        if (out_end_of_text !== want.end_of_text) begin
          $display("%0t: end_of_text expected %b actual %b", $time, want.end_of_text,
                   out_end_of_text);
          mismatch_count++;
        end
      end
    end
  end

  // short messages that end at each group position, extreme bytes,
  // sextets that map to dash and underscore
  task automatic test_directed();
    idle_pct = 20;
    msg_bytes = '{8'h00};
    send_message();
    msg_bytes = '{8'hFF};
    send_message();
    msg_bytes = '{8'hFB, 8'hF0};
    send_message();
    msg_bytes = '{8'h00, 8'h00};
    send_message();
    msg_bytes = '{8'hFB, 8'hFF, 8'hBF};
    send_message();
    msg_bytes = '{8'h00, 8'h00, 8'h00};
    send_message();
    msg_bytes = '{8'h4D, 8'h61, 8'h6E, 8'h80, 8'h7F};
    send_message();
    msg_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'h01};
    send_message();
  endtask

  // random messages, first with no idling, then light, then heavy
  task automatic test_random_stream();
    int sent;
    int phase_pct[3];
    phase_pct = '{0, 25, 60};
    for (int p = 0; p < 3; p++) begin
      idle_pct = phase_pct[p];
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        fill_random_message(pick_length());
        send_message();
        sent += msg_bytes.size();
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block fills
  // up and has to drop in_ready
  task automatic test_output_hold();
    idle_pct = 0;
    wait_drained();
    hold_request = HOLD_CYCLES;
    fill_random_message(24);
    send_message();
  endtask

  // sender stops mid-message until every owed character is out, then goes on;
  // the group state has to survive the idle block
  task automatic test_pause_mid_message();
    int len;
    int cut;
    idle_pct = 20;
    repeat (6) begin
      len = $urandom_range(2, 12);
      cut = $urandom_range(1, len - 1);
      fill_random_message(len);
      for (int i = 0; i < len; i++) begin
        if (i == cut) begin
          wait_drained();
        end
        send_byte(msg_bytes[i], i == len - 1, pick_gap());
      end
    end
  endtask

  initial begin
    // synchronous reset held at the start, once
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_stream();
    test_output_hold();
    test_pause_mid_message();

    wait_drained();
    in_valid <= 1'b0;
    // room for any stray character after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
